FILE: rtl/bba_pkg.sv
// Shared types, codes and defaults for the bitmap block allocator.
`default_nettype none
package bba_pkg;

  localparam int NUM_BLOCKS_DEF  = 1024;
  localparam int CACHE_DEPTH_DEF = 10;
  localparam int ROOT_BLOCK_DEF  = 2;

  localparam int BLOCK_W  = 10;
  localparam int COUNT_W  = 11;
  localparam int WORD_W   = 32;
  localparam int WORD_LOG = 5;
  localparam int FIRST_FREEABLE = 3;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_FORMAT = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;
  localparam logic [1:0] ST_RESERVED = 2'd2;
  localparam logic [1:0] ST_ALREADY  = 2'd3;

  typedef struct packed {
    logic [1:0]         command;
    logic [BLOCK_W-1:0] block_number;
  } request_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] granted_block;
    logic [1:0]         status;
    logic [COUNT_W-1:0] free_remaining;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/bitmap_block_allocator.sv
// Bitmap block allocator with a free-block cache, top level.
// Allocate: pops a non-empty cache; with an empty cache it moves free blocks of the 32-bit bitmap
// rows, from row 0, into the cache until it is full or the last row is done, then pops one.
// Free: reads the row, then checks and clears its bit. Reserved free, allocate with no blocks left,
// unknown command: answered in the next cycle. Format rewrites every row; so does reset, busy high.
// One result per command, a one-cycle done strobe; the receiver cannot stall.
`default_nettype none
module bitmap_block_allocator
  import bba_pkg::*;
#(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int CACHE_DEPTH = CACHE_DEPTH_DEF,
  parameter int ROOT_BLOCK  = ROOT_BLOCK_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output logic     done,
  output result_t  result
);

  localparam int ROWS      = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int IDX_W     = ROW_W + WORD_LOG;
  localparam int BLK_W     = $clog2(NUM_BLOCKS);
  localparam int XW        = (IDX_W > BLOCK_W) ? IDX_W : BLOCK_W;
  localparam int GW        = (BLK_W > BLOCK_W) ? BLK_W : BLOCK_W;
  localparam int CW        = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CNT_W     = $clog2(CACHE_DEPTH + 1);
  localparam int LAST_BITS = NUM_BLOCKS - (ROWS - 1) * WORD_W;

  localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [WORD_W-1:0]  LAST_MASK = WORD_W'((64'(1) << LAST_BITS) - 64'(1));
  localparam logic [WORD_W-1:0]  ROW0_INIT = WORD_W'(3) | (WORD_W'(1) << ROOT_BLOCK);
  localparam logic [COUNT_W-1:0] REMAIN_INIT = COUNT_W'(NUM_BLOCKS - 3);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_CLEAR     = 9'b000000010,
    S_FREE_CHK  = 9'b000000100,
    S_SCAN_RD   = 9'b000001000,
    S_SCAN_LOAD = 9'b000010000,
    S_SCAN_PICK = 9'b000100000,
    S_POP       = 9'b001000000,
    S_POP_OUT   = 9'b010000000,
    S_SPARE     = 9'b100000000
  } state_t;

  state_t              state, state_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [WORD_W-1:0]   word, word_next;
  logic [BLOCK_W-1:0]  blk_q;
  logic                fmt, fmt_next;
  logic [CNT_W-1:0]    cache_count, cache_count_next;
  logic [COUNT_W-1:0]  remaining, remaining_next;
  logic                done_next;
  result_t             result_next;

  logic [WORD_W-1:0]   bitmap [ROWS];
  logic [WORD_W-1:0]   rdata;
  logic                mem_we;
  logic [ROW_W-1:0]    mem_waddr, rd_addr;
  logic [WORD_W-1:0]   mem_wdata;

  logic [BLK_W-1:0]    cache_mem [CACHE_DEPTH];
  logic [BLK_W-1:0]    cache_rdata;
  logic                cache_we;
  logic [CW-1:0]       cache_raddr;
  logic [BLK_W-1:0]    cache_wdata;

  logic [XW-1:0]       req_x, blkq_x;
  logic [WORD_LOG-1:0] pick;
  logic [IDX_W-1:0]    pick_idx;
  logic [CNT_W-1:0]    count_m1;
  logic [GW-1:0]       num_x;
  logic [WORD_W-1:0]   row_mask;

  function automatic logic [WORD_LOG-1:0] first_free(input logic [WORD_W-1:0] w);
    logic [WORD_LOG-1:0] p;
    p = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) p = WORD_LOG'(i);
    end
    return p;
  endfunction

  assign busy     = (state != S_IDLE);
  assign req_x    = XW'(request.block_number);
  assign blkq_x   = XW'(blk_q);
  assign pick     = first_free(word);
  assign pick_idx = {row, pick};
  assign count_m1 = cache_count - 1'b1;
  assign num_x    = GW'(cache_rdata);
  assign row_mask = (row == LAST_ROW) ? LAST_MASK : '1;

  always_comb begin
    state_next       = state;
    row_next         = row;
    word_next        = word;
    fmt_next         = fmt;
    cache_count_next = cache_count;
    remaining_next   = remaining;
    done_next        = 1'b0;
    result_next      = result;
    mem_we           = 1'b0;
    mem_waddr        = row;
    mem_wdata        = word;
    rd_addr          = row;
    cache_we         = 1'b0;
    cache_raddr      = count_m1[CW-1:0];
    cache_wdata      = pick_idx[BLK_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (start) begin
          result_next.granted_block  = '0;
          result_next.status         = ST_OK;
          result_next.free_remaining = remaining;
          case (request.command)
            CMD_ALLOC: begin
              if (remaining == '0) begin
                result_next.status = ST_NONE;
                done_next          = 1'b1;
              end else if (cache_count != '0) begin
                state_next = S_POP;
              end else begin
                row_next   = '0;
                state_next = S_SCAN_RD;
              end
            end
            CMD_FREE: begin
              if (request.block_number < BLOCK_W'(FIRST_FREEABLE)) begin
                result_next.status = ST_RESERVED;
                done_next          = 1'b1;
              end else if (32'(request.block_number) >= NUM_BLOCKS) begin
                result_next.status = ST_ALREADY;
                done_next          = 1'b1;
              end else begin
                rd_addr    = req_x[IDX_W-1:WORD_LOG];
                state_next = S_FREE_CHK;
              end
            end
            CMD_FORMAT: begin
              row_next   = '0;
              fmt_next   = 1'b1;
              state_next = S_CLEAR;
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = (row == '0) ? ROW0_INIT : '0;
        if (row == LAST_ROW) begin
          cache_count_next = '0;
          remaining_next   = REMAIN_INIT;
          state_next       = S_IDLE;
          if (fmt) begin
            result_next.granted_block  = '0;
            result_next.status         = ST_OK;
            result_next.free_remaining = REMAIN_INIT;
            done_next                  = 1'b1;
          end
          fmt_next = 1'b0;
        end else begin
          row_next = row + 1'b1;
        end
      end
      S_FREE_CHK: begin
        state_next = S_IDLE;
        done_next  = 1'b1;
        if (!rdata[blkq_x[WORD_LOG-1:0]]) begin
          result_next.status = ST_ALREADY;
        end else begin
          mem_we                     = 1'b1;
          mem_waddr                  = blkq_x[IDX_W-1:WORD_LOG];
          mem_wdata                  = rdata & ~(WORD_W'(1) << blkq_x[WORD_LOG-1:0]);
          remaining_next             = remaining + 1'b1;
          result_next.free_remaining = remaining + 1'b1;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_LOAD;
      end
      S_SCAN_LOAD: begin
        word_next  = rdata | ~row_mask;
        state_next = S_SCAN_PICK;
      end
      S_SCAN_PICK: begin
        if ((~word != '0) && (cache_count < CNT_W'(CACHE_DEPTH))) begin
          word_next        = word | (WORD_W'(1) << pick);
          cache_we         = 1'b1;
          cache_count_next = cache_count + 1'b1;
        end else begin
          mem_we = 1'b1;
          if ((cache_count == CNT_W'(CACHE_DEPTH)) || (row == LAST_ROW)) begin
            if (cache_count == '0) begin
              result_next.status = ST_NONE;
              done_next          = 1'b1;
              state_next         = S_IDLE;
            end else begin
              state_next = S_POP;
            end
          end else begin
            row_next   = row + 1'b1;
            state_next = S_SCAN_RD;
          end
        end
      end
      S_POP: begin
        cache_count_next = count_m1;
        state_next       = S_POP_OUT;
      end
      S_POP_OUT: begin
        remaining_next             = remaining - 1'b1;
        result_next.free_remaining = remaining - 1'b1;
        if (num_x < GW'(FIRST_FREEABLE)) begin
          result_next.status        = ST_NONE;
          result_next.granted_block = '0;
        end else begin
          result_next.status        = ST_OK;
          result_next.granted_block = num_x[BLOCK_W-1:0];
        end
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bitmap[mem_waddr] <= mem_wdata;
    end
    rdata <= bitmap[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cache_we) begin
      cache_mem[cache_count[CW-1:0]] <= cache_wdata;
    end
    cache_rdata <= cache_mem[cache_raddr];
  end

  always_ff @(posedge clk) begin
    word   <= word_next;
    result <= result_next;
    if (start && !busy) begin
      blk_q <= request.block_number;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      row         <= '0;
      fmt         <= 1'b0;
      cache_count <= '0;
      remaining   <= REMAIN_INIT;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      row         <= row_next;
      fmt         <= fmt_next;
      cache_count <= cache_count_next;
      remaining   <= remaining_next;
      done        <= done_next;
    end
  end

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("transfer neither started work nor produced a result");

  a_cache_bound: assert property (@(posedge clk) disable iff (rst)
    cache_count <= CNT_W'(CACHE_DEPTH))
    else $error("free cache overfilled");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still working");

  a_grant_ok: assert property (@(posedge clk) disable iff (rst)
    (done && (result.granted_block != '0)) |-> (result.status == ST_OK))
    else $error("block granted with failing status");

endmodule
`default_nettype wire

FILE: sim/bitmap_block_allocator_test.sv
// Self-checking testbench for the bitmap block allocator with a live command predictor.
module bitmap_block_allocator_test;
  import bba_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 150;
  localparam int MAX_GAP       = 13;
  localparam int REPORT_LIMIT  = 10;

  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    request_t req;
    bit       recycle;
    bit       settle;
  } job_t;

  logic     clk;
  logic     rst = 1'b1;
  logic     start = 1'b0;
  request_t request = '0;
  logic     busy;
  logic     done;
  result_t  result;

  bitmap_block_allocator dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .request(request),
    .busy(busy),
    .done(done),
    .result(result)
  );

  logic [NUM_BLOCKS_DEF-1:0] block_taken;
  logic [BLOCK_W-1:0]        spare_blocks [CACHE_DEPTH_DEF];
  int unsigned               spare_count;
  logic [COUNT_W-1:0]        free_left;
  logic [COUNT_W-1:0]        in_use;

  job_t               jobs[$];
  result_t            results_due[$];
  logic [BLOCK_W-1:0] granted_pool[$];

  int transfers_made = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int cycles         = 0;
  int gap_left       = 0;
  int calm_left      = 0;
  int grants         = 0;
  int out_of_space   = 0;
  int frees_done     = 0;
  int frees_refused  = 0;
  int formats        = 0;
  int unknowns       = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function void format_volume();
    block_taken = '0;
    block_taken[0] = 1'b1;
    block_taken[1] = 1'b1;
    block_taken[ROOT_BLOCK_DEF] = 1'b1;
    spare_count = 0;
    in_use = COUNT_W'(3);
    free_left = COUNT_W'(NUM_BLOCKS_DEF - 3);
  endfunction

  function automatic result_t forecast_result(request_t req);
    result_t            r;
    logic [BLOCK_W-1:0] popped;
    r = '0;
    r.status = ST_OK;
    case (req.command)
      CMD_ALLOC: begin
        if (free_left == 0) begin
          r.status = ST_NONE;
        end else begin
          if (spare_count == 0) begin
            for (int b = 0; b < NUM_BLOCKS_DEF && spare_count < CACHE_DEPTH_DEF; b++) begin
              if (!block_taken[b]) begin
                block_taken[b] = 1'b1;
                spare_blocks[spare_count] = BLOCK_W'(b);
                spare_count++;
              end
            end
          end
          if (spare_count == 0 || spare_count > CACHE_DEPTH_DEF) begin
            r.status = ST_NONE;
          end else begin
            free_left = free_left - 1'b1;
            in_use = in_use + 1'b1;
            spare_count--;
            popped = spare_blocks[spare_count];
            if (popped < FIRST_FREEABLE) begin
              r.status = ST_NONE;
            end else begin
              r.granted_block = popped;
              granted_pool.push_back(popped);
            end
          end
        end
        if (r.status == ST_OK) grants++;
        else out_of_space++;
      end
      CMD_FREE: begin
        if (req.block_number < FIRST_FREEABLE) begin
          r.status = ST_RESERVED;
        end else if (!block_taken[req.block_number]) begin
          r.status = ST_ALREADY;
        end else begin
          block_taken[req.block_number] = 1'b0;
          free_left = free_left + 1'b1;
          in_use = in_use - 1'b1;
        end
        if (r.status == ST_OK) frees_done++;
        else frees_refused++;
      end
      CMD_FORMAT: begin
        format_volume();
        formats++;
      end
      default: begin
        unknowns++;
      end
    endcase
    r.free_remaining = free_left;
    return r;
  endfunction

  function void add_job(logic [1:0] cmd, logic [BLOCK_W-1:0] blk, bit recycle = 1'b0,
                        bit settle = 1'b0);
    job_t j;
    j.req.command = cmd;
    j.req.block_number = blk;
    j.recycle = recycle;
    j.settle = settle;
    jobs.push_back(j);
  endfunction

  function void queue_mixed(int count);
    int roll;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 50) add_job(CMD_ALLOC, BLOCK_W'($urandom()));
      else if (roll < 75) add_job(CMD_FREE, BLOCK_W'($urandom()), 1'b1);
      else if (roll < 86) add_job(CMD_FREE, BLOCK_W'($urandom()));
      else if (roll < 90) add_job(CMD_FREE, BLOCK_W'($urandom_range(0, FIRST_FREEABLE - 1)));
      else if (roll < 94) add_job(CMD_UNUSED, BLOCK_W'($urandom()));
      else if (roll < 97) add_job(CMD_FORMAT, BLOCK_W'($urandom()));
      else add_job(CMD_FREE, BLOCK_W'($urandom()), 1'b1, 1'b1);
    end
  endfunction

  // driver: present queued commands, predict each transfer
  always @(posedge clk) begin
    job_t    next_job;
    int      pick;
    logic    accepted;
    if (rst) begin
      start <= 1'b0;
      request <= '0;
    end else begin
      accepted = start && !busy;
      if (accepted) begin
        results_due.push_back(forecast_result(request));
        transfers_made <= transfers_made + 1;
        if (calm_left != 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, MAX_GAP);
          if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(20, 60);
        end
      end
      if (!start || accepted) begin
        if (gap_left != 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (jobs.size() != 0 &&
                     !(jobs[0].settle && (accepted || transfers_made != results_seen))) begin
          next_job = jobs.pop_front();
          if (next_job.recycle && granted_pool.size() != 0) begin
            pick = $urandom_range(0, granted_pool.size() - 1);
            next_job.req.block_number = granted_pool[pick];
            granted_pool.delete(pick);
          end
          start <= 1'b1;
          request <= next_job.req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: check every strobed result against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && done === 1'b1) begin
      results_seen <= results_seen + 1;
      if (results_seen == transfers_made) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected transfer: block %0d status %0d free %0d",
                   result.granted_block, result.status, result.free_remaining);
      end else begin
        want = results_due.pop_front();
        if (result.granted_block !== want.granted_block || result.status !== want.status ||
            result.free_remaining !== want.free_remaining) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("transfer %0d: expected block %0d status %0d free %0d, got %0d %0d %0d",
                     results_seen, want.granted_block, want.status, want.free_remaining,
                     result.granted_block, result.status, result.free_remaining);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("cycle limit hit, %0d commands still owed", transfers_made - results_seen);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    format_volume();

    add_job(CMD_ALLOC, 10'h000);
    add_job(CMD_ALLOC, 10'h3FF);
    add_job(CMD_FREE, 10'd0);
    add_job(CMD_FREE, 10'd1);
    add_job(CMD_FREE, 10'd2);
    add_job(CMD_FREE, 10'h3FF);
    add_job(CMD_FREE, 10'd12);
    add_job(CMD_FREE, 10'd12);
    add_job(CMD_FREE, 10'd3);
    add_job(CMD_FREE, 10'h2AA);
    add_job(CMD_FREE, 10'h155);
    add_job(CMD_UNUSED, 10'h3FF);
    add_job(CMD_UNUSED, 10'h000);
    repeat (9) add_job(CMD_ALLOC, 10'h155);
    add_job(CMD_FORMAT, 10'h2AA, 1'b0, 1'b1);
    add_job(CMD_ALLOC, 10'h000);

    queue_mixed(170);

    // exhaust the volume, then run dry and recover
    add_job(CMD_FORMAT, BLOCK_W'($urandom()), 1'b0, 1'b1);
    repeat (1030) add_job(CMD_ALLOC, BLOCK_W'($urandom()));
    repeat (4) add_job(CMD_FREE, BLOCK_W'($urandom()), 1'b1);
    repeat (6) add_job(CMD_ALLOC, BLOCK_W'($urandom()));
    add_job(CMD_FREE, BLOCK_W'($urandom()));
    add_job(CMD_FORMAT, BLOCK_W'($urandom()), 1'b0, 1'b1);

    queue_mixed(160);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (jobs.size() != 0 || start) @(posedge clk);
    while (results_seen != transfers_made) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("%0d commands: %0d grants, %0d out-of-space answers, %0d frees, %0d refused frees",
             transfers_made, grants, out_of_space, frees_done, frees_refused);
    $display("%0d formats, %0d unknown commands, %0d mismatches",
             formats, unknowns, mismatches);
    if (results_seen != transfers_made)
      $display("%0d commands never answered", transfers_made - results_seen);
    if (mismatches == 0 && results_seen == transfers_made) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
